/* rtl/core/pcm_linear_resampler_macros.svh */
// Assertion macros shared by the resampler RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef PCM_LINEAR_RESAMPLER_MACROS_SVH
`define PCM_LINEAR_RESAMPLER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PLR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define PLR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/plr_pkg.sv */
// Shared constants, types and the sample widening function of the resampler.
// No dependencies; used by the interfaces, controller, datapath and top level.
package plr_pkg;

  // Default build values
  localparam int PLR_OUTPUT_RATE   = 44100;
  localparam int PLR_FRACTION_BITS = 16;

  // Field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int SRC_RATE_W = 18;
  localparam int SUM_W      = SRC_RATE_W + 1;  // phase plus source rate
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam int SKIP_W     = 4;
  localparam int CNT_W      = 4;

  localparam int MAX_RESULTS = 12;
  localparam int SKIP_MAX    = 15;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE   = 2'd2;

  // Sample format codes
  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_S8  = 2'd1;
  localparam logic [1:0] FMT_U16 = 2'd2;
  localparam logic [1:0] FMT_S16 = 2'd3;

  // Channel count codes
  localparam logic [1:0] CH_MONO   = 2'd1;
  localparam logic [1:0] CH_STEREO = 2'd2;

  // Register reset values
  localparam logic [1:0]            FMT_RESET      = FMT_S16;
  localparam logic [1:0]            CH_RESET       = CH_STEREO;
  localparam logic [SRC_RATE_W-1:0] SRC_RATE_RESET = 18'd44100;

  // Controller to datapath commands
  typedef struct packed {
    logic take;       // latch widened frame
    logic commit;     // new frame becomes previous frame
    logic skip;       // count down one skipped interval
    logic st_prod;    // weight reciprocal product, phase sum
    logic st_est;     // weight estimate, whole reciprocal product
    logic st_chk;     // weight check product, whole estimate
    logic st_fix;     // corrected weight, whole check product
    logic st_blend;   // blend products, phase remainder
    logic emit;       // load interpolated frame, advance phase
    logic emit_pass;  // load frame unchanged
    logic last;       // run_last of the loaded frame
  } plr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pass;          // pass-through configuration
    logic have_prev;     // a frame has been stored
    logic skip_pending;  // intervals still to skip
    logic whole_nz;      // phase crosses a source frame
    logic out_free;      // output register can take a frame
  } plr_status_t;

  // Widen a raw sample to signed 16-bit
  function automatic logic signed [SAMPLE_W-1:0] plr_widen(input logic [SAMPLE_W-1:0] raw,
                                                           input logic [1:0] fmt);
    logic signed [SAMPLE_W-1:0] v;
    unique case (fmt)
      FMT_U8:  v = {~raw[7], raw[6:0], 8'h00};
      FMT_S8:  v = {raw[7:0], 8'h00};
      FMT_U16: v = {~raw[15], raw[14:0]};
      FMT_S16: v = raw;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/plr_frame_if.sv */
// Source frame channel: valid/ready handshake with raw left and right samples.
// Depends on plr_pkg.
interface plr_frame_if import plr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] left_raw;
  logic [SAMPLE_W-1:0] right_raw;

  modport source (output valid, left_raw, right_raw, input ready);
  modport sink (input valid, left_raw, right_raw, output ready);
endinterface

/* rtl/core/plr_result_if.sv */
// Result channel: valid/ready handshake with a signed stereo frame and run_last.
// Depends on plr_pkg.
interface plr_result_if import plr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic                       run_last;

  modport source (output valid, left_out, right_out, run_last, input ready);
  modport sink (input valid, left_out, right_out, run_last, output ready);
endinterface

/* rtl/core/plr_ctrl.sv */
// Sequencer of the resampler: accepts frames and steps the datapath per output.
// Depends on plr_pkg and pcm_linear_resampler_macros.svh.
`include "pcm_linear_resampler_macros.svh"

module plr_ctrl import plr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  plr_status_t sts,
  output plr_cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SKIP  = 4'd1;
  localparam logic [3:0] ST_PROD  = 4'd2;
  localparam logic [3:0] ST_EST   = 4'd3;
  localparam logic [3:0] ST_CHK   = 4'd4;
  localparam logic [3:0] ST_FIX   = 4'd5;
  localparam logic [3:0] ST_BLEND = 4'd6;
  localparam logic [3:0] ST_EMIT  = 4'd7;
  localparam logic [3:0] ST_PASS  = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RESULTS - 1);

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          priority if (sts.pass)       state_next = ST_PASS;
          else if (!sts.have_prev)     state_next = ST_DONE;
          else if (sts.skip_pending)   state_next = ST_SKIP;
          else                         state_next = ST_PROD;
        end
      end
      ST_SKIP: begin
        cmd.skip   = 1'b1;
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      ST_PROD: begin
        cmd.st_prod = 1'b1;
        state_next  = ST_EST;
      end
      ST_EST: begin
        cmd.st_est = 1'b1;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        cmd.st_chk = 1'b1;
        state_next = ST_FIX;
      end
      ST_FIX: begin
        cmd.st_fix = 1'b1;
        state_next = ST_BLEND;
      end
      ST_BLEND: begin
        cmd.st_blend = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = sts.whole_nz || (cnt == CNT_LAST);
          state_next = cmd.last ? ST_DONE : ST_PROD;
        end
      end
      ST_PASS: begin
        if (sts.out_free) begin
          cmd.emit_pass = 1'b1;
          cmd.last      = 1'b1;
          state_next    = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output count within one frame's run
  always_comb begin
    cnt_next = cnt;
    if (cmd.take) begin
      cnt_next = '0;
    end else if (cmd.emit && !cmd.last) begin
      cnt_next = cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  `PLR_ASSERT_NOW(a_last_at_cap, clk, rst, cmd.emit && (cnt == CNT_LAST), cmd.last, "twelfth output not flagged last")
  `PLR_ASSERT_NEXT(a_last_ends_run, clk, rst, cmd.emit && cmd.last, state == ST_DONE, "run went on after last output")
  `PLR_ASSERT_NOW(a_cnt_range, clk, rst, 1'b1, cnt <= CNT_LAST, "output count beyond cap")

endmodule

/* rtl/core/plr_datapath.sv */
// Resampler datapath: configuration, frame and phase state, reciprocal
// division steps, blend multipliers and the output register. Depends on plr_pkg
// and pcm_linear_resampler_macros.svh.
`include "pcm_linear_resampler_macros.svh"

module plr_datapath import plr_pkg::*; #(
  parameter int OUTPUT_RATE   = PLR_OUTPUT_RATE,
  parameter int FRACTION_BITS = PLR_FRACTION_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  plr_cmd_t                   cmd,
  output plr_status_t                sts,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic [SAMPLE_W-1:0]        left_raw,
  input  logic [SAMPLE_W-1:0]        right_raw,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] left_out,
  output logic signed [SAMPLE_W-1:0] right_out,
  output logic                       run_last
);

  localparam int FB     = FRACTION_BITS;
  localparam int RATE_W = $clog2(OUTPUT_RATE + 1);
  localparam int PR_W   = $clog2(OUTPUT_RATE);
  // Reciprocal: floor(2^K / rate), exact to within one for values below 2^SUM_W
  localparam int K      = FB + SUM_W;
  localparam longint unsigned RECIP = (64'd1 << K) / OUTPUT_RATE;
  localparam int RW     = $clog2(RECIP + 1);
  localparam int PW     = SUM_W + RW;
  localparam int WH_W   = PW - K;
  localparam int WHL_W  = (WH_W + 1 > SKIP_W + 1) ? WH_W + 1 : SKIP_W + 1;
  localparam int XW     = FB + SUM_W;
  localparam int CHK_W  = FB + RATE_W;
  localparam int SCHK_W = WH_W + RATE_W;
  localparam int DW     = (SCHK_W > SUM_W) ? SCHK_W : SUM_W;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int ACC_W  = FB + SAMPLE_W + 2;

  localparam logic [RW-1:0]         RECIP_V    = RW'(RECIP);
  localparam logic [CHK_W-1:0]      RATE_CHK   = CHK_W'(OUTPUT_RATE);
  localparam logic [SCHK_W-1:0]     RATE_SCHK  = SCHK_W'(OUTPUT_RATE);
  localparam logic [XW-1:0]         RATE_X     = XW'(OUTPUT_RATE);
  localparam logic [XW-1:0]         RATE_X2    = XW'(2 * OUTPUT_RATE);
  localparam logic [SUM_W-1:0]      RATE_S     = SUM_W'(OUTPUT_RATE);
  localparam logic [SUM_W:0]        RATE_S2    = (SUM_W + 1)'(2 * OUTPUT_RATE);
  localparam logic [RATE_W-1:0]     RATE_R     = RATE_W'(OUTPUT_RATE);
  localparam logic [SRC_RATE_W-1:0] RATE_SRC   = SRC_RATE_W'(OUTPUT_RATE);
  localparam logic [WHL_W-1:0]      SKIP_MAX_W = WHL_W'(SKIP_MAX);
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'((64'd1 << FB) - 1);

  // Configuration registers
  logic [1:0]            sample_format;
  logic [1:0]            channel_count;
  logic [SRC_RATE_W-1:0] source_rate;

  // Frame and phase state
  logic signed [SAMPLE_W-1:0] new_left, new_right;
  logic signed [SAMPLE_W-1:0] prev_left, prev_right;
  logic                       have_previous;
  logic [PR_W-1:0]            phase_remainder;
  logic [SKIP_W-1:0]          frames_until_output;

  // Step registers
  logic [SUM_W-1:0]         psum;
  logic [PW-1:0]            prod_w, prod_s;
  logic [FB-1:0]            w_est, weight;
  logic [CHK_W-1:0]         w_chk;
  logic [WH_W-1:0]          whole_est;
  logic [SCHK_W-1:0]        s_chk;
  logic [SUM_W-1:0]         s_rem;
  logic signed [ACC_W-1:0]  prod_left, prod_right;

  // Combinational
  logic signed [SAMPLE_W-1:0] wide_left, wide_right;
  logic [XW-1:0]              w_rem;
  logic                       s_over;
  logic [WHL_W-1:0]           whole, whole_m1;
  logic [SKIP_W-1:0]          skip_load;
  logic [SUM_W-1:0]           phase_sum_next;
  logic signed [DIFF_W-1:0]   diff_left, diff_right;
  logic signed [ACC_W-1:0]    acc_left, acc_right, acc_left_t, acc_right_t;
  logic signed [ACC_W-1:0]    weight_s;

  // Widening and mono duplication
  always_comb begin
    wide_left  = plr_widen(left_raw, sample_format);
    wide_right = (channel_count == CH_MONO) ? wide_left : plr_widen(right_raw, sample_format);
  end

  // Reciprocal corrections and phase update
  always_comb begin
    w_rem          = (XW'(phase_remainder) << FB) - XW'(w_chk);
    s_over         = (s_rem >= RATE_S);
    whole          = WHL_W'(whole_est) + WHL_W'(s_over);
    whole_m1       = whole - WHL_W'(1);
    skip_load      = (whole_m1 > SKIP_MAX_W) ? SKIP_W'(SKIP_MAX) : SKIP_W'(whole_m1);
    phase_sum_next = s_over ? (s_rem - RATE_S) : s_rem;
  end

  // Blend: prev * 2^FB + (new - prev) * w, truncated toward zero
  always_comb begin
    diff_left   = DIFF_W'(new_left) - DIFF_W'(prev_left);
    diff_right  = DIFF_W'(new_right) - DIFF_W'(prev_right);
    weight_s    = $signed(ACC_W'(weight));
    acc_left    = (ACC_W'(prev_left) <<< FB) + prod_left;
    acc_right   = (ACC_W'(prev_right) <<< FB) + prod_right;
    acc_left_t  = acc_left + (acc_left[ACC_W-1] ? ROUND_BIAS : ACC_W'(0));
    acc_right_t = acc_right + (acc_right[ACC_W-1] ? ROUND_BIAS : ACC_W'(0));
  end

  // Status to the controller
  always_comb begin
    sts.pass         = (sample_format == FMT_S16) && (channel_count == CH_STEREO) &&
                       (source_rate == RATE_SRC);
    sts.have_prev    = have_previous;
    sts.skip_pending = (frames_until_output != '0);
    sts.whole_nz     = (whole_est != '0) || s_over;
    sts.out_free     = !out_valid || out_ready;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= FMT_RESET;
      channel_count <= CH_RESET;
      source_rate   <= SRC_RATE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SAMPLE_FORMAT: sample_format <= cfg_data[1:0];
        CFG_CHANNEL_COUNT: channel_count <= cfg_data[1:0];
        CFG_SOURCE_RATE:   source_rate   <= cfg_data[SRC_RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame state, phase and skip count
  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous       <= 1'b0;
      phase_remainder     <= '0;
      frames_until_output <= '0;
    end else begin
      if (cmd.commit) begin
        have_previous <= 1'b1;
      end
      if (cmd.skip) begin
        frames_until_output <= frames_until_output - SKIP_W'(1);
      end else if (cmd.emit && sts.whole_nz) begin
        frames_until_output <= skip_load;
      end
      if (cmd.emit) begin
        phase_remainder <= PR_W'(phase_sum_next);
      end
    end
  end

  // Sample payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      new_left  <= wide_left;
      new_right <= wide_right;
    end
    if (cmd.commit) begin
      prev_left  <= new_left;
      prev_right <= new_right;
    end
  end

  // Division and blend steps, one register stage per step
  always_ff @(posedge clk) begin
    if (cmd.st_prod) begin
      prod_w <= PW'(phase_remainder) * PW'(RECIP_V);
      psum   <= SUM_W'(phase_remainder) + SUM_W'(source_rate);
    end
    if (cmd.st_est) begin
      w_est  <= prod_w[SUM_W +: FB];
      prod_s <= PW'(psum) * PW'(RECIP_V);
    end
    if (cmd.st_chk) begin
      w_chk     <= CHK_W'(w_est) * RATE_CHK;
      whole_est <= prod_s[PW-1:K];
    end
    if (cmd.st_fix) begin
      weight <= w_est + FB'(w_rem >= RATE_X);
      s_chk  <= SCHK_W'(whole_est) * RATE_SCHK;
    end
    if (cmd.st_blend) begin
      prod_left  <= ACC_W'(diff_left) * weight_s;
      prod_right <= ACC_W'(diff_right) * weight_s;
      s_rem      <= SUM_W'(DW'(psum) - DW'(s_chk));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_pass) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      left_out  <= acc_left_t[FB +: SAMPLE_W];
      right_out <= acc_right_t[FB +: SAMPLE_W];
      run_last  <= cmd.last;
    end else if (cmd.emit_pass) begin
      left_out  <= new_left;
      right_out <= new_right;
      run_last  <= cmd.last;
    end
  end

  `PLR_ASSERT_NOW(a_phase_range, clk, rst, 1'b1, RATE_W'(phase_remainder) < RATE_R, "phase out of range")
  `PLR_ASSERT_NOW(a_weight_rem, clk, rst, cmd.st_fix, w_rem < RATE_X2, "weight estimate off by more than one")
  `PLR_ASSERT_NOW(a_whole_rem, clk, rst, cmd.emit, (SUM_W + 1)'(s_rem) < RATE_S2, "whole estimate off by more than one")
  `PLR_ASSERT_NEXT(a_skip_step, clk, rst, cmd.skip, frames_until_output == $past(frames_until_output) - SKIP_W'(1), "skip count did not step down")

endmodule

/* rtl/core/pcm_linear_resampler.sv */
// Linear-interpolation sample rate converter. Each request on frames carries one
// source frame (8 or 16 bit, signed or unsigned, mono or stereo per the
// registers); it is widened to signed 16-bit stereo and zero or more frames at
// OUTPUT_RATE come out on results, the last of each run flagged by run_last. One
// frame is worked at a time: a stored or skipped frame goes from idle to done or
// skip, a pass-through frame through pass and done; each of at most 12 outputs of
// a frame runs the six-step sequence of reciprocal multiplies, their corrections
// and the blend multipliers. Waits on results.ready stall the emit and pass
// steps. The output register lets a new frame be taken while a finished result
// is still waiting. The user must write registers through cfg_write, cfg_index
// and cfg_data only while the block is idle; the block does not enforce this.
// Depends on plr_pkg, plr_frame_if, plr_result_if, plr_ctrl and plr_datapath.
module pcm_linear_resampler import plr_pkg::*; #(
  parameter int OUTPUT_RATE   = PLR_OUTPUT_RATE,
  parameter int FRACTION_BITS = PLR_FRACTION_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  plr_frame_if.sink             frames,
  plr_result_if.source          results,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  plr_cmd_t    cmd;
  plr_status_t sts;

  // Sequencer
  plr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (frames.valid),
    .in_ready (frames.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic, state and output register
  plr_datapath #(
    .OUTPUT_RATE   (OUTPUT_RATE),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .left_raw  (frames.left_raw),
    .right_raw (frames.right_raw),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .left_out  (results.left_out),
    .right_out (results.right_out),
    .run_last  (results.run_last)
  );

endmodule
